/* rtl/nei_pkg.sv */
`default_nettype none

package nei_pkg;

    localparam int VAL_W     = 32;
    localparam int NODE_W    = 10;
    localparam int VEC_W     = 3 * VAL_W;
    localparam int PROD_W    = 65;
    localparam int TERM_W    = 49;
    localparam int SUM_W     = 51;
    localparam int DIV_N_W   = 48;
    localparam int DIV_STEPS = 48;
    localparam int CNT_W     = 6;
    localparam int S_DATA_W  = 144;
    localparam int S_USER_W  = 3;
    localparam int M_DATA_W  = 304;
    localparam int ADDR_W    = 4;
    localparam int GAMMA_W   = 17;
    localparam logic [GAMMA_W-1:0] GAMMA_ONE = 17'd65536;

    typedef enum logic [2:0] {
        FN_LOAD_POS  = 3'd0,
        FN_LOAD_VEL  = 3'd1,
        FN_INIT      = 3'd2,
        FN_PREDICT   = 3'd3,
        FN_CORRECT   = 3'd4,
        FN_BALLISTIC = 3'd5,
        FN_PULL_BACK = 3'd6,
        FN_READ      = 3'd7
    } func_t;

    typedef enum logic [1:0] {
        REG_TIME_STEP = 2'd0,
        REG_GAMMA     = 2'd1,
        REG_MASS_TOL  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic capture;
        logic mem_rd;
        logic div_start;
        logic mul1;
        logic mul2;
        logic commit;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

    typedef struct packed {
        logic [VAL_W-1:0] val;
        logic             hit;
    } sat_t;

    function automatic sat_t clamp32(input logic signed [SUM_W-1:0] v);
        sat_t r;
        if (v > 51'sd2147483647)
        begin
            r.val = 32'h7FFF_FFFF;
            r.hit = 1'b1;
        end
        else if (v < -51'sd2147483648)
        begin
            r.val = 32'h8000_0000;
            r.hit = 1'b1;
        end
        else
        begin
            r.val = v[VAL_W-1:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // q32.32 to q16.16, half up
    function automatic logic signed [TERM_W-1:0] rnd16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W:0] s;
        s = {p[PROD_W-1], p} + 66'sd32768;
        return s[PROD_W-1:16];
    endfunction

endpackage

`default_nettype wire

/* rtl/newmark_explicit_node_integrator.sv */
// channel   dir  signals                          contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser one operation on one node
// m_*       out  m_tvalid m_tready m_tdata m_tuser node state after the operation
// apb       in   psel penable pwrite paddr pwdata  time_step, gamma_new, mass_tolerance
//
// m_tvalid rises after the accepting edge via states RD, MUL1, DIVW, MUL2 and
// COMMIT and the output register; a new transaction is taken only back in IDLE;
// in-range init and correct with mass above tolerance wait on the bit-serial divider
// after reset a clearing pass writes zeros to all NODE_COUNT entries
// with s_tready low
// one operation in flight; the result register holds while m_tready is low
// and the next transaction is accepted meanwhile
`default_nettype none

module newmark_explicit_node_integrator #(
    parameter int NODE_COUNT = 1024,
    parameter int DIMENSIONS = 3
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // node, fixed_node, node_mass, value_x, value_y, value_z, zero pad
    input  wire  [nei_pkg::S_DATA_W-1:0]      s_tdata,
    // func
    input  wire  [nei_pkg::S_USER_W-1:0]      s_tuser,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // node_out, pos_x..z, vel_x..z, acc_x..z, zero pad
    output logic [nei_pkg::M_DATA_W-1:0]      m_tdata,
    // saturated
    output logic                              m_tuser,
    input  wire                               psel,
    input  wire                               penable,
    input  wire                               pwrite,
    input  wire  [nei_pkg::ADDR_W-1:0]        paddr,
    input  wire  [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import nei_pkg::*;

    localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

    logic [31:0]         time_step_reg;
    logic [GAMMA_W-1:0]  gamma_reg;
    logic [31:0]         mass_tol_reg;
    logic                wr_en;
    cmd_t                cmd;
    status_t             stat;
    logic [AW-1:0]       clr_addr;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg <= 32'd65536;
            gamma_reg     <= 17'd32768;
            mass_tol_reg  <= '0;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_TIME_STEP:
                begin
                    time_step_reg <= pwdata;
                end
                REG_GAMMA:
                begin
                    gamma_reg <= (pwdata[GAMMA_W-1:0] > GAMMA_ONE) ? GAMMA_ONE
                                                                   : pwdata[GAMMA_W-1:0];
                end
                REG_MASS_TOL:
                begin
                    mass_tol_reg <= pwdata;
                end
                default:
                begin
                    mass_tol_reg <= mass_tol_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_TIME_STEP: prdata = time_step_reg;
            REG_GAMMA:     prdata = 32'(gamma_reg);
            REG_MASS_TOL:  prdata = mass_tol_reg;
            default:       prdata = '0;
        endcase
    end

    nei_ctrl #(
        .NODE_COUNT (NODE_COUNT),
        .AW         (AW)
    ) u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd),
        .clr_addr (clr_addr)
    );

    nei_dp #(
        .NODE_COUNT (NODE_COUNT),
        .DIMENSIONS (DIMENSIONS),
        .AW         (AW)
    ) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .clr_addr       (clr_addr),
        .s_tdata        (s_tdata),
        .s_tuser        (s_tuser),
        .time_step      (time_step_reg),
        .gamma_new      (gamma_reg),
        .mass_tolerance (mass_tol_reg),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser)
    );

endmodule

`default_nettype wire

/* rtl/nei_div.sv */
`default_nettype none

module nei_div
(
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     start,
    input  wire  signed [31:0]      f,
    input  wire         [31:0]      m,
    output logic                    busy,
    output logic        [31:0]      q,
    output logic                    sat
);
    import nei_pkg::*;

    logic [VAL_W:0]     rem_reg, rem_next;
    logic [DIV_N_W-1:0] quo_reg, quo_next;
    logic [VAL_W-1:0]   m_reg;
    logic               pos_reg;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VAL_W-1:0]   mag;
    logic [VAL_W:0]     trial;
    logic               fits;

    assign mag   = f[VAL_W-1] ? (~f + 32'd1) : f;
    assign trial = {rem_reg[VAL_W-1:0], quo_reg[DIV_N_W-1]};
    assign fits  = trial >= {1'b0, m_reg};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        cnt_next = cnt_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = {mag, 16'd0} + {17'd0, m[VAL_W-1:1]};
            cnt_next = CNT_W'(DIV_STEPS);
        end
        else if (cnt_reg != '0)
        begin
            rem_next = fits ? (trial - {1'b0, m_reg}) : trial;
            quo_next = {quo_reg[DIV_N_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            m_reg   <= m;
            pos_reg <= (f > 32'sd0);
        end
    end

    assign busy = (cnt_reg != '0);

    always_comb
    begin
        if (pos_reg)
        begin
            sat = quo_reg > 48'h0000_8000_0000;
            q   = sat ? 32'h8000_0000 : (~quo_reg[VAL_W-1:0] + 32'd1);
        end
        else
        begin
            sat = quo_reg > 48'h0000_7FFF_FFFF;
            q   = sat ? 32'h7FFF_FFFF : quo_reg[VAL_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* rtl/nei_ctrl.sv */
`default_nettype none

module nei_ctrl #(
    parameter int NODE_COUNT = 1024,
    parameter int AW         = 10
)
(
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire                       m_tready,
    input  nei_pkg::status_t          stat,
    output nei_pkg::cmd_t             cmd,
    output logic [AW-1:0]             clr_addr
);
    import nei_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_RD     = 7'b0000100,
        ST_MUL1   = 7'b0001000,
        ST_DIVW   = 7'b0010000,
        ST_MUL2   = 7'b0100000,
        ST_COMMIT = 7'b1000000
    } state_t;

    state_t         state_reg, state_next;
    logic [AW-1:0]  clr_reg, clr_next;
    logic           out_valid_reg, out_valid_next;
    logic           out_free;

    assign out_free = !out_valid_reg || m_tready;

    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(NODE_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.mem_rd    = 1'b1;
                cmd.div_start = 1'b1;
                state_next    = ST_MUL1;
            end
            ST_MUL1:
            begin
                cmd.mul1   = 1'b1;
                state_next = ST_DIVW;
            end
            ST_DIVW:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                cmd.mul2   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign clr_addr = clr_reg;

endmodule

`default_nettype wire

/* rtl/nei_dp.sv */
`default_nettype none

module nei_dp #(
    parameter int NODE_COUNT = 1024,
    parameter int DIMENSIONS = 3,
    parameter int AW         = 10
)
(
    input  wire                                clk,
    input  wire                                rst_n,
    input  nei_pkg::cmd_t                      cmd,
    output nei_pkg::status_t                   stat,
    input  wire  [AW-1:0]                      clr_addr,
    input  wire  [nei_pkg::S_DATA_W-1:0]       s_tdata,
    input  wire  [nei_pkg::S_USER_W-1:0]       s_tuser,
    input  wire  [31:0]                        time_step,
    input  wire  [nei_pkg::GAMMA_W-1:0]        gamma_new,
    input  wire  [31:0]                        mass_tolerance,
    output logic [nei_pkg::M_DATA_W-1:0]       m_tdata,
    output logic                               m_tuser
);
    import nei_pkg::*;

    logic [VEC_W-1:0] pos_mem [NODE_COUNT];
    logic [VEC_W-1:0] vel_mem [NODE_COUNT];
    logic [VEC_W-1:0] acc_mem [NODE_COUNT];

    func_t              func_reg;
    logic [NODE_W-1:0]  node_reg;
    logic               fixed_reg;
    logic [VAL_W-1:0]   mass_reg;
    logic [VEC_W-1:0]   val_reg;
    logic [VEC_W-1:0]   x_rd_reg, v_rd_reg, a_rd_reg;
    logic [VAL_W-1:0]   h_reg, dtold_reg, dtnew_reg;
    logic [63:0]        dtsq;
    logic [48:0]        old_prod, new_prod;

    logic [AW-1:0]      addr;
    logic               in_range, heavy, is_corr, need_div;
    logic [VEC_W-1:0]   wr_x, wr_v, wr_a;
    logic [2:0]         lane_sat, lane_busy;

    logic [NODE_W-1:0]  out_node_reg;
    logic [VEC_W-1:0]   out_x_reg, out_v_reg, out_a_reg;
    logic               out_sat_reg;

    assign addr     = AW'(node_reg);
    assign in_range = 32'(node_reg) < 32'(NODE_COUNT);
    assign heavy    = mass_reg > mass_tolerance;
    assign is_corr  = func_reg == FN_CORRECT;
    assign need_div = in_range && heavy && (func_reg == FN_INIT || func_reg == FN_CORRECT);

    // coefficients are registered behind the config registers and follow them after a write
    assign dtsq     = 64'(time_step) * 64'(time_step);
    assign old_prod = 49'(GAMMA_ONE - gamma_new) * 49'(time_step) + 49'd32768;
    assign new_prod = 49'(gamma_new) * 49'(time_step) + 49'd32768;

    always_ff @(posedge clk)
    begin
        h_reg     <= 32'((dtsq + 64'h1_0000_0000) >> 33);
        dtold_reg <= old_prod[47:16];
        dtnew_reg <= new_prod[47:16];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            node_reg  <= s_tdata[9:0];
            fixed_reg <= s_tdata[10];
            mass_reg  <= s_tdata[42:11];
            val_reg   <= s_tdata[138:43];
            func_reg  <= func_t'(s_tuser);
        end
        if (cmd.mem_rd)
        begin
            x_rd_reg <= pos_mem[addr];
            v_rd_reg <= vel_mem[addr];
            a_rd_reg <= acc_mem[addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.clear)
        begin
            pos_mem[clr_addr] <= '0;
            vel_mem[clr_addr] <= '0;
            acc_mem[clr_addr] <= '0;
        end
        else if (cmd.commit && in_range)
        begin
            pos_mem[addr] <= wr_x;
            vel_mem[addr] <= wr_v;
            acc_mem[addr] <= wr_a;
        end
    end

    for (genvar d = 0; d < 3; d++)
    begin : g_lane
        if (d < DIMENSIONS)
        begin : g_on
            logic signed [VAL_W-1:0]  xv, vv, av, fv, an;
            logic                     an_sat;
            logic signed [VAL_W-1:0]  mul_a;
            logic        [VAL_W-1:0]  mul_b;
            logic signed [VAL_W:0]    mul_bs;
            logic signed [PROD_W-1:0] prod;
            logic signed [PROD_W-1:0] p1_reg, p2_reg;
            logic signed [TERM_W-1:0] t1, t2;
            sat_t                     cp, cb, cm, cv;
            logic [VAL_W-1:0]         nx, nv, na;
            logic                     ls;

            assign xv = x_rd_reg[VAL_W*d +: VAL_W];
            assign vv = v_rd_reg[VAL_W*d +: VAL_W];
            assign av = a_rd_reg[VAL_W*d +: VAL_W];
            assign fv = val_reg[VAL_W*d +: VAL_W];

            nei_div u_div
            (
                .clk   (clk),
                .rst_n (rst_n),
                .start (cmd.div_start && need_div),
                .f     (fv),
                .m     (mass_reg),
                .busy  (lane_busy[d]),
                .q     (an),
                .sat   (an_sat)
            );

            always_comb
            begin
                if (cmd.mul2)
                begin
                    mul_a = is_corr ? an : av;
                    mul_b = is_corr ? dtnew_reg : h_reg;
                end
                else
                begin
                    mul_a = is_corr ? av : vv;
                    mul_b = is_corr ? dtold_reg : time_step;
                end
            end

            assign mul_bs = signed'({1'b0, mul_b});
            assign prod   = mul_a * mul_bs;

            always_ff @(posedge clk)
            begin
                if (cmd.mul1)
                begin
                    p1_reg <= prod;
                end
                if (cmd.mul2)
                begin
                    p2_reg <= prod;
                end
            end

            assign t1 = rnd16(p1_reg);
            assign t2 = rnd16(p2_reg);
            assign cp = clamp32(SUM_W'(xv) + SUM_W'(t1) + SUM_W'(t2));
            assign cb = clamp32(SUM_W'(xv) + SUM_W'(t1));
            assign cm = clamp32(SUM_W'(xv) - SUM_W'(t1) - SUM_W'(t2));
            assign cv = clamp32(SUM_W'(vv) + SUM_W'(t1) + SUM_W'(t2));

            always_comb
            begin
                nx = xv;
                nv = vv;
                na = av;
                ls = 1'b0;
                case (func_reg)
                    FN_LOAD_POS:
                    begin
                        nx = fv;
                    end
                    FN_LOAD_VEL:
                    begin
                        nv = fv;
                    end
                    FN_INIT:
                    begin
                        na = heavy ? an : '0;
                        ls = heavy && an_sat;
                    end
                    FN_PREDICT:
                    begin
                        if (!fixed_reg)
                        begin
                            nx = cp.val;
                            ls = cp.hit;
                        end
                    end
                    FN_CORRECT:
                    begin
                        if (heavy)
                        begin
                            nv = cv.val;
                            na = an;
                            ls = an_sat || cv.hit;
                        end
                        else
                        begin
                            na = '0;
                        end
                    end
                    FN_BALLISTIC:
                    begin
                        nx = cb.val;
                        ls = cb.hit;
                    end
                    FN_PULL_BACK:
                    begin
                        nx = cm.val;
                        ls = cm.hit;
                    end
                    default:
                    begin
                        ls = 1'b0;
                    end
                endcase
            end

            assign wr_x[VAL_W*d +: VAL_W] = nx;
            assign wr_v[VAL_W*d +: VAL_W] = nv;
            assign wr_a[VAL_W*d +: VAL_W] = na;
            assign lane_sat[d] = ls;
        end
        else
        begin : g_off
            assign wr_x[VAL_W*d +: VAL_W] = '0;
            assign wr_v[VAL_W*d +: VAL_W] = '0;
            assign wr_a[VAL_W*d +: VAL_W] = '0;
            assign lane_sat[d]  = 1'b0;
            assign lane_busy[d] = 1'b0;
        end
    end

    assign stat.div_busy = |lane_busy;

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            out_node_reg <= node_reg;
            out_x_reg    <= in_range ? wr_x : '0;
            out_v_reg    <= in_range ? wr_v : '0;
            out_a_reg    <= in_range ? wr_a : '0;
            out_sat_reg  <= in_range && (|lane_sat);
        end
    end

    assign m_tdata = {6'd0, out_a_reg, out_v_reg, out_x_reg, out_node_reg};
    assign m_tuser = out_sat_reg;

endmodule

`default_nettype wire

/* rtl/nei_check.sv */
`default_nettype none

module nei_check #(
    parameter int NODE_COUNT = 1024
)
(
    input wire                          clk,
    input wire                          rst_n,
    input wire                          s_tvalid,
    input wire                          s_tready,
    input wire                          m_tvalid,
    input wire                          m_tready,
    input wire [nei_pkg::M_DATA_W-1:0]  m_tdata,
    input wire                          m_tuser
);
    import nei_pkg::*;

    // one transaction in flight
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted twice in a row");

    // no result in the cycle right after acceptance
    a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared too early");

    // node beyond the store reports zero state
    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (32'(m_tdata[9:0]) >= 32'(NODE_COUNT))
        |-> (m_tdata[M_DATA_W-1:10] == '0) && !m_tuser)
        else $error("out of range node returned state");

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

endmodule

bind newmark_explicit_node_integrator nei_check #(.NODE_COUNT(NODE_COUNT)) u_nei_check (.*);

`default_nettype wire
